// ===== hw/rtl/skf_pkg.sv =====
// shared constants, control word layout and microprogram for the scalar kalman filter
// no dependencies; used by every other file of the block
`default_nettype none

package skf_pkg;

    localparam int DATA_W = 32;                   // value width, q16.16
    localparam int FRAC_W = 16;                   // fraction bits of values and gain
    localparam int PROD_W = DATA_W + 1 + FRAC_W;  // widest product
    localparam int PC_W   = 3;
    localparam int CNT_W  = $clog2(FRAC_W);

    // datapath operations
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_PRED = 3'd1;
    localparam logic [2:0] OP_DEN  = 3'd2;
    localparam logic [2:0] OP_CHK  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_MULE = 3'd5;
    localparam logic [2:0] OP_MULV = 3'd6;
    localparam logic [2:0] OP_EMIT = 3'd7;

    // sequencing conditions
    localparam logic [2:0] CND_NEXT     = 3'd0;
    localparam logic [2:0] CND_ALWAYS   = 3'd1;
    localparam logic [2:0] CND_FLAG     = 3'd2;
    localparam logic [2:0] CND_LOOP     = 3'd3;
    localparam logic [2:0] CND_WAIT_IN  = 3'd4;
    localparam logic [2:0] CND_WAIT_OUT = 3'd5;

    // step addresses
    localparam logic [PC_W-1:0] ST_LOAD = 3'd0;
    localparam logic [PC_W-1:0] ST_PRED = 3'd1;
    localparam logic [PC_W-1:0] ST_DEN  = 3'd2;
    localparam logic [PC_W-1:0] ST_CHK  = 3'd3;
    localparam logic [PC_W-1:0] ST_DIV  = 3'd4;
    localparam logic [PC_W-1:0] ST_MULE = 3'd5;
    localparam logic [PC_W-1:0] ST_MULV = 3'd6;
    localparam logic [PC_W-1:0] ST_EMIT = 3'd7;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // datapath control from the sequencer
    typedef struct packed {
        logic [2:0] op;
        logic       take;   // input transfer this cycle
        logic       emit;   // result goes to the output register
    } dp_ctrl_t;

    // microprogram rom
    function automatic ucode_t skf_ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        begin
            unique case (pc)
                ST_LOAD: w = '{op: OP_LOAD, cond: CND_WAIT_IN,  target: ST_PRED};
                ST_PRED: w = '{op: OP_PRED, cond: CND_NEXT,     target: ST_DEN};
                ST_DEN:  w = '{op: OP_DEN,  cond: CND_NEXT,     target: ST_CHK};
                ST_CHK:  w = '{op: OP_CHK,  cond: CND_FLAG,     target: ST_MULE};
                ST_DIV:  w = '{op: OP_DIV,  cond: CND_LOOP,     target: ST_DIV};
                ST_MULE: w = '{op: OP_MULE, cond: CND_NEXT,     target: ST_MULV};
                ST_MULV: w = '{op: OP_MULV, cond: CND_NEXT,     target: ST_EMIT};
                ST_EMIT: w = '{op: OP_EMIT, cond: CND_WAIT_OUT, target: ST_LOAD};
                default: w = '{op: OP_LOAD, cond: CND_ALWAYS,   target: ST_LOAD};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/skf_sequencer.sv =====
// microcode sequencer: step counter, divide loop counter and jump logic
// depends on skf_pkg for the control word layout and the program rom
`default_nettype none

module skf_sequencer (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    input  wire                 out_free,
    input  wire                 flag,
    output skf_pkg::dp_ctrl_t   ctrl,
    output logic                in_ready
);
    import skf_pkg::*;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ucode_t           uw;
    logic [PC_W-1:0]  pc_inc;

    assign uw     = skf_ucode(pc_reg);
    assign pc_inc = pc_reg + PC_W'(1);

    always_comb begin
        unique case (uw.cond)
            CND_NEXT:     pc_next = pc_inc;
            CND_ALWAYS:   pc_next = uw.target;
            CND_FLAG:     pc_next = flag ? uw.target : pc_inc;
            CND_LOOP:     pc_next = (cnt_reg != '0) ? uw.target : pc_inc;
            CND_WAIT_IN:  pc_next = in_valid ? pc_inc : pc_reg;
            CND_WAIT_OUT: pc_next = out_free ? uw.target : pc_reg;
            default:      pc_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (uw.op == OP_CHK) begin
            cnt_next = CNT_W'(FRAC_W - 1);
        end else if (uw.op == OP_DIV && cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    assign in_ready  = (uw.op == OP_LOAD);
    assign ctrl.op   = uw.op;
    assign ctrl.take = (uw.op == OP_LOAD) && in_valid;
    assign ctrl.emit = (uw.op == OP_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= ST_LOAD;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/skf_datapath.sv =====
// filter datapath: estimate and variance state, adder, restoring divider step, multiplier
// depends on skf_pkg; driven one operation per cycle by skf_sequencer
`default_nettype none

module skf_datapath (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  skf_pkg::dp_ctrl_t           ctrl,
    input  wire  [skf_pkg::DATA_W-1:0]  sample,
    input  wire  [skf_pkg::DATA_W-1:0]  process_noise,
    input  wire  [skf_pkg::DATA_W-1:0]  measure_noise,
    output logic                        flag,
    output logic [skf_pkg::DATA_W-1:0]  estimate
);
    import skf_pkg::*;

    // state
    logic [DATA_W-1:0] est_reg, est_next;
    logic [DATA_W-1:0] var_reg, var_next;
    // working registers
    logic [DATA_W-1:0] smp_reg;
    logic [DATA_W-1:0] pmid_reg;
    logic [DATA_W:0]   den_reg;
    logic [DATA_W:0]   rem_reg;
    logic [FRAC_W-1:0] gain_reg;
    logic [DATA_W:0]   mag_reg;
    logic              neg_reg;
    logic [DATA_W:0]   step_reg;

    logic [DATA_W:0]   psum;
    logic [DATA_W:0]   diff;
    logic              den_zero;
    logic              gain_sat;
    logic [DATA_W+1:0] shifted;
    logic [DATA_W+1:0] trial;
    logic [PROD_W-1:0] prod_e;
    logic [PROD_W-1:0] prod_v;
    logic [FRAC_W:0]   one_minus_gain;
    logic [DATA_W:0]   est_sum;

    assign psum     = {1'b0, var_reg} + {1'b0, process_noise};
    assign diff     = {smp_reg[DATA_W-1], smp_reg} - {est_reg[DATA_W-1], est_reg};
    assign den_zero = (den_reg == '0);
    assign gain_sat = ({1'b0, pmid_reg} >= den_reg);
    assign flag     = den_zero || gain_sat;

    // one restoring divide step
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};

    assign one_minus_gain = {1'b1, {FRAC_W{1'b0}}} - {1'b0, gain_reg};
    assign prod_e = PROD_W'(mag_reg) * PROD_W'(gain_reg);
    assign prod_v = PROD_W'(pmid_reg) * PROD_W'(one_minus_gain);

    // step never exceeds the difference, so the sum stays in range
    assign est_sum = neg_reg ? ({est_reg[DATA_W-1], est_reg} - step_reg)
                             : ({est_reg[DATA_W-1], est_reg} + step_reg);

    always_comb begin
        est_next = est_reg;
        var_next = var_reg;
        if (ctrl.op == OP_MULV) begin
            est_next = est_sum[DATA_W-1:0];
            var_next = prod_v[FRAC_W +: DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
            var_reg <= '0;
        end else begin
            est_reg <= est_next;
            var_reg <= var_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: begin
                if (ctrl.take) begin
                    smp_reg <= sample;
                end
            end
            OP_PRED: begin
                pmid_reg <= psum[DATA_W] ? {DATA_W{1'b1}} : psum[DATA_W-1:0];
            end
            OP_DEN: begin
                den_reg <= {1'b0, pmid_reg} + {1'b0, measure_noise};
                neg_reg <= diff[DATA_W];
                mag_reg <= diff[DATA_W] ? (~diff + (DATA_W+1)'(1)) : diff;
            end
            OP_CHK: begin
                rem_reg <= {1'b0, pmid_reg};
                if (!den_zero && gain_sat) begin
                    gain_reg <= {FRAC_W{1'b1}};
                end else begin
                    gain_reg <= '0;
                end
            end
            OP_DIV: begin
                if (!trial[DATA_W+1]) begin
                    rem_reg  <= trial[DATA_W:0];
                    gain_reg <= {gain_reg[FRAC_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= shifted[DATA_W:0];
                    gain_reg <= {gain_reg[FRAC_W-2:0], 1'b0};
                end
            end
            OP_MULE: begin
                step_reg <= prod_e[FRAC_W +: DATA_W+1];
            end
            default: begin
            end
        endcase
    end

    assign estimate = est_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scalar_kalman_filter_core.sv =====
// top level of the scalar kalman filter: stream ports, noise registers, output register
// depends on skf_pkg, skf_sequencer and skf_datapath
//
// usage:
//   s_ channel carries raw samples (signed q16.16), m_ channel carries the filtered
//   estimate (signed q16.16), one result per sample, in order. a transfer takes place
//   at a rising edge with tvalid and tready both high.
//   cfg port: cfg_wr_en with cfg_addr 0 writes process noise q, 1 writes measurement
//   noise r (both unsigned q16.16). write only while no sample is in flight.
//   an input sample goes through the microprogram's load, predict, denominator and check
//   steps, the 16-step restoring divider that forms the gain, two multiply steps and the
//   emit step, which waits for a free output register; the divider is skipped when the gain
//   is known at once (zero denominator or zero r). all steps share one datapath, so a new
//   sample is taken only once the emit step for the last one has run.
//   reset (aresetn low, synchronous) clears estimate and variance to zero, loads
//   q = 655 and r = 65536 and empties the output register.
//   when the receiver stalls the result waits in the output register; the next sample
//   is still taken and worked on, and the sequencer holds at its emit step until the
//   output register frees up.
`default_nettype none

module scalar_kalman_filter_core (
    input  wire                         aclk,
    input  wire                         aresetn,
    // input stream
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [skf_pkg::DATA_W-1:0]  s_tdata,      // [31:0] sample
    // result stream
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [skf_pkg::DATA_W-1:0]  m_tdata,      // [31:0] estimate
    // configuration writes
    input  wire                         cfg_wr_en,
    input  wire  [0:0]                  cfg_addr,
    input  wire  [skf_pkg::DATA_W-1:0]  cfg_wr_data
);
    import skf_pkg::*;

    localparam logic [0:0] REG_PROCESS_NOISE = 1'b0;
    localparam logic [0:0] REG_MEASURE_NOISE = 1'b1;

    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;

    dp_ctrl_t          ctrl;
    logic              flag;
    logic              out_free;
    logic [DATA_W-1:0] estimate;

    // noise registers
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PROCESS_NOISE: q_next = cfg_wr_data;
                REG_MEASURE_NOISE: r_next = cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // output register frees when empty or when its transfer completes
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg         <= DATA_W'(655);
            r_reg         <= DATA_W'(65536);
            out_valid_reg <= 1'b0;
        end else begin
            q_reg         <= q_next;
            r_reg         <= r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_data_reg <= estimate;
        end
    end

    skf_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .flag     (flag),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    skf_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .sample        (s_tdata),
        .process_noise (q_reg),
        .measure_noise (r_reg),
        .flag          (flag),
        .estimate      (estimate)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== bench/scalar_kalman_filter_core_tb.sv =====
// self-checking bench for scalar_kalman_filter_core: drives raw samples, predicts every
// filtered estimate with its own fixed-point kalman update and compares each result transfer
// depends on skf_pkg and scalar_kalman_filter_core
`default_nettype none

module scalar_kalman_filter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam int CLK_HALF     = 6;          // 12 ns period
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE       = 30;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_REPORTS  = 50;

    // register indexes of the configuration port
    localparam logic [0:0] REG_PROCESS_NOISE = 1'b0;
    localparam logic [0:0] REG_MEASURE_NOISE = 1'b1;

    localparam logic [63:0] WORD_MAX = (64'd1 << DATA_W) - 64'd1;
    localparam logic [63:0] GAIN_ONE = 64'd1 << FRAC_W;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata     = '0;    // [31:0] sample
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [DATA_W-1:0]   m_tdata;             // [31:0] estimate
    logic                cfg_wr_en   = 1'b0;
    logic [0:0]          cfg_addr    = '0;
    logic [DATA_W-1:0]   cfg_wr_data = '0;

    scalar_kalman_filter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // filter state as the bench sees it
    logic [DATA_W-1:0]   q_noise;
    logic [DATA_W-1:0]   r_noise;
    longint              est_kept;
    logic [DATA_W-1:0]   var_kept;

    logic [DATA_W-1:0]   samples_pending[$];  // waiting for the driver
    logic [DATA_W-1:0]   estimates_due[$];    // predicted, not yet seen on m_
    logic [DATA_W-1:0]   est_want;

    int                  errors      = 0;
    longint              cycles      = 0;
    bit                  src_idle_en = 1'b0;
    bit                  rx_idle_en  = 1'b0;
    int                  src_gap     = 0;
    int                  rx_gap      = 0;
    int                  hold_reqs   = 0;    // bumped by the stimulus to ask for a hold-off
    int                  hold_seen   = 0;
    int                  hold_left   = 0;
    logic [DATA_W-1:0]   sensor_level = '0;

    // one kalman update: advances the kept estimate and variance, returns the new estimate
    function automatic logic [DATA_W-1:0] kalman_update(input logic [DATA_W-1:0] raw);
        longint          meas;
        longint          diff;
        logic [63:0]     p_pred;
        logic [63:0]     den;
        logic [63:0]     gain;
        logic [63:0]     mag;
        logic [63:0]     step;
        logic [63:0]     var_next;
        begin
            meas   = $signed(raw);
            // predicted variance saturates at the top of the unsigned range
            p_pred = {32'd0, var_kept} + {32'd0, q_noise};
            if (p_pred > WORD_MAX) begin
                p_pred = WORD_MAX;
            end
            den = p_pred + {32'd0, r_noise};
            // gain in q0.16, floor; zero denominator gives 0, r = 0 pins it just below one
            if (den == 64'd0) begin
                gain = 64'd0;
            end else if (p_pred >= den) begin
                gain = GAIN_ONE - 64'd1;
            end else begin
                gain = (p_pred << FRAC_W) / den;
            end
            // correction step truncated toward zero
            diff = meas - est_kept;
            if (diff < 0) begin
                mag      = -diff;
                step     = (mag * gain) >> FRAC_W;
                est_kept = est_kept - longint'(step);
            end else begin
                mag      = diff;
                step     = (mag * gain) >> FRAC_W;
                est_kept = est_kept + longint'(step);
            end
            var_next = (p_pred * (GAIN_ONE - gain)) >> FRAC_W;
            var_kept = var_next[DATA_W-1:0];
            return est_kept[DATA_W-1:0];
        end
    endfunction

    // idle lengths: mostly short, a few long
    function automatic int gap_len();
        int pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                return $urandom_range(1, 3);
            end else if (pick < 95) begin
                return $urandom_range(4, 12);
            end
            return $urandom_range(20, 80);
        end
    endfunction

    // noise register values, extremes included
    function automatic logic [DATA_W-1:0] noise_value();
        int pick;
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0: begin
                    return '0;
                end
                1: begin
                    return WORD_MAX[DATA_W-1:0];
                end
                2: begin
                    return $urandom_range(0, 65535);
                end
                3: begin
                    return $urandom_range(32'h0001_0000, 32'h0100_0000);
                end
                default: begin
                    return $urandom;
                end
            endcase
        end
    endfunction

    // sensor-like readings: a drifting level with noise, plus wild values and extremes
    function automatic logic [DATA_W-1:0] sensor_sample();
        int pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                return $urandom;
            end else if (pick < 7) begin
                if ($urandom_range(0, 15) == 0) begin
                    sensor_level = $urandom;
                end
                return sensor_level + $urandom_range(0, 8191) - 32'd4096;
            end else if (pick < 9) begin
                return $urandom_range(0, 2047) - 32'd1024;
            end
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
    endfunction

    initial begin
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    // run limit, well above the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d estimates outstanding", $time,
                     estimates_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // register shadow and reset of the predicted state, sampled like the block does
    always @(posedge aclk) begin
        if (!aresetn) begin
            q_noise  = 32'd655;
            r_noise  = 32'd65536;
            est_kept = 0;
            var_kept = '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PROCESS_NOISE: q_noise = cfg_wr_data;
                REG_MEASURE_NOISE: r_noise = cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sample driver: predicts on each input transfer, then offers the next pending sample
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                estimates_due.push_back(kalman_update(s_tdata));
            end
            // slot free: nothing offered or the last one just went through
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap  = src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (samples_pending.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (src_idle_en && $urandom_range(0, 99) < 20) begin
                    src_gap  = gap_len() - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= samples_pending.pop_front();
                end
            end
        end
    end

    // result monitor: checks each result transfer against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (estimates_due.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: estimate %h arrived with none expected", $time, m_tdata);
                    end
                end else begin
                    est_want = estimates_due.pop_front();
                    if (m_tdata !== est_want) begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: estimate mismatch, expected %h actual %h", $time,
                                     est_want, m_tdata);
                        end
                    end
                end
            end
            // ready pattern: long hold-off on request, otherwise random stalls
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready  <= 1'b0;
            end else if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   = rx_gap - 1;
                m_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
                rx_gap   = gap_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // blocks until every sample has gone in and every estimate has come out
    task automatic wait_drained();
        begin
            do begin
                @(posedge aclk);
            end while (samples_pending.size() != 0 || s_tvalid || estimates_due.size() != 0);
        end
    endtask

    // noise registers are only touched with the block idle
    task automatic set_noise(input logic [DATA_W-1:0] q_val, input logic [DATA_W-1:0] r_val);
        begin
            wait_drained();
            repeat (SETTLE) @(posedge aclk);
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= REG_PROCESS_NOISE;
            cfg_wr_data <= q_val;
            @(posedge aclk);
            cfg_addr    <= REG_MEASURE_NOISE;
            cfg_wr_data <= r_val;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
        end
    endtask

    initial begin
        logic [DATA_W-1:0] q_pick;
        logic [DATA_W-1:0] r_pick;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset noise values, starting from zero variance; full-scale swings
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'hFFFF_FFFF);
        samples_pending.push_back(32'h0000_0000);
        samples_pending.push_back(32'h0001_0000);
        samples_pending.push_back(32'h0000_0001);
        samples_pending.push_back(32'h5555_5555);
        samples_pending.push_back(32'hAAAA_AAAA);

        // no measurement noise: gain pinned just below one
        set_noise(32'd655, 32'd0);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h1234_5678);

        // no noise at all: variance drains to zero, then the denominator is zero
        set_noise(32'd0, 32'd0);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h4000_0000);
        samples_pending.push_back(32'h0000_0000);
        samples_pending.push_back(32'hC000_0000);

        // both noise terms at full scale, predicted variance saturates
        set_noise(WORD_MAX[DATA_W-1:0], WORD_MAX[DATA_W-1:0]);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h0000_0000);
        samples_pending.push_back(32'hFFFF_FFFF);

        // random phases over several noise settings and idling patterns
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    q_pick = 32'd655;
                    r_pick = 32'd65536;
                end
                2: begin
                    q_pick = WORD_MAX[DATA_W-1:0];
                    r_pick = WORD_MAX[DATA_W-1:0];
                end
                3: begin
                    q_pick = '0;
                    r_pick = noise_value();
                end
                4: begin
                    q_pick = noise_value();
                    r_pick = '0;
                end
                default: begin
                    q_pick = noise_value();
                    r_pick = noise_value();
                end
            endcase
            set_noise(q_pick, r_pick);
            src_idle_en = (ph != 0) && (ph != 3);
            rx_idle_en  = (ph != 0) && (ph != 4);
            // one phase starts with a long receiver hold-off so the block backs up
            if (ph == 1) begin
                hold_reqs = hold_reqs + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                samples_pending.push_back(sensor_sample());
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && estimates_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
